// File: sv/clope_pkg.sv
// Package: shared widths, kind codes, command/status structs and the 2^-2^-(j+1) table.
package clope_pkg;

  localparam int KIND_W   = 2;
  localparam int ITEM_W   = 12;
  localparam int REP_W    = 16;
  localparam int QV_W     = 48;
  localparam int WID_W    = 13;
  localparam int TXN_W    = 16;
  localparam int TOT_W    = 32;
  localparam int PEND_W   = 13;

  localparam logic [REP_W-1:0]  REP_RESET = 16'd4096;
  localparam logic [PEND_W-1:0] PEND_MAX  = 13'd8191;
  localparam logic [QV_W-1:0]   Q48_MAX   = {QV_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SKIP   = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_TXN,
    ST_PMUL,
    ST_PCLAMP,
    ST_LOGINIT,
    ST_LOGSQ,
    ST_EMUL,
    ST_EXPSTEP,
    ST_QA,
    ST_QB,
    ST_QC,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic accept_ok;
    logic rd;
    logic upd;
    logic txn;
    logic pmul;
    logic pclamp;
    logic loginit;
    logic logsq;
    logic emul;
    logic expstep;
    logic qa;
    logic qb;
    logic qc;
    logic shift;
    logic out_load;
    logic cnt_clr;
    logic cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic iter_done;
    logic req_skip;
    logic item_last;
    logic out_free;
  } status_t;

  typedef logic [15:0][31:0] tk_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    n    = n_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Entry j holds 2^-(2^-(j+1)) in Q0.32.
  function automatic tk_tab_t make_tk();
    tk_tab_t     tab;
    logic [63:0] t;
    t = isqrt64(64'd1 << 63);
    for (int j = 0; j < 16; j++) begin
      tab[j] = t[31:0];
      t = isqrt64(t << 32);
    end
    return tab;
  endfunction

  localparam tk_tab_t TK = make_tk();

endpackage

// File: sv/clope_if.sv
// Interfaces: item request channel, result channel and configuration write channel.
interface clope_req_if;
  logic                           valid;
  logic                           ready;
  logic [clope_pkg::KIND_W-1:0]   kind;
  logic [clope_pkg::ITEM_W-1:0]   item;
  logic                           last;
  modport source (output valid, kind, item, last, input ready);
  modport sink   (input valid, kind, item, last, output ready);
endinterface

interface clope_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [clope_pkg::QV_W-1:0] quality_value;
  logic                              cluster_empty;
  logic [clope_pkg::WID_W-1:0]       cluster_width;
  logic [clope_pkg::TXN_W-1:0]       transaction_total;
  logic                              missing_item;
  logic                              saturated;
  modport source (output valid, quality_value, cluster_empty, cluster_width,
                  transaction_total, missing_item, saturated, input ready);
  modport sink   (input valid, quality_value, cluster_empty, cluster_width,
                  transaction_total, missing_item, saturated, output ready);
endinterface

interface clope_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [clope_pkg::REP_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: sv/clope_ctrl.sv
// Controller: sequences clear pass, per-item counter update and the quality steps.
module clope_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  clope_pkg::status_t  status,
  output clope_pkg::cmd_t     cmd
);

  clope_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clope_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      clope_pkg::ST_CLEAR:   if (status.clr_done) state_next = clope_pkg::ST_IDLE;
      clope_pkg::ST_IDLE:    if (req_valid && !status.req_skip) state_next = clope_pkg::ST_READ;
      clope_pkg::ST_READ:    state_next = clope_pkg::ST_UPDATE;
      clope_pkg::ST_UPDATE: begin
        state_next = status.item_last ? clope_pkg::ST_TXN : clope_pkg::ST_IDLE;
      end
      clope_pkg::ST_TXN:     state_next = clope_pkg::ST_PMUL;
      clope_pkg::ST_PMUL:    state_next = clope_pkg::ST_PCLAMP;
      clope_pkg::ST_PCLAMP:  state_next = clope_pkg::ST_LOGINIT;
      clope_pkg::ST_LOGINIT: state_next = clope_pkg::ST_LOGSQ;
      clope_pkg::ST_LOGSQ:   if (status.iter_done) state_next = clope_pkg::ST_EMUL;
      clope_pkg::ST_EMUL:    state_next = clope_pkg::ST_EXPSTEP;
      clope_pkg::ST_EXPSTEP: if (status.iter_done) state_next = clope_pkg::ST_QA;
      clope_pkg::ST_QA:      state_next = clope_pkg::ST_QB;
      clope_pkg::ST_QB:      state_next = clope_pkg::ST_QC;
      clope_pkg::ST_QC:      state_next = clope_pkg::ST_SHIFT;
      clope_pkg::ST_SHIFT:   state_next = clope_pkg::ST_FINISH;
      clope_pkg::ST_FINISH:  if (status.out_free) state_next = clope_pkg::ST_IDLE;
      default:               state_next = clope_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      clope_pkg::ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      clope_pkg::ST_IDLE:    cmd.accept_ok = 1'b1;
      clope_pkg::ST_READ:    cmd.rd = 1'b1;
      clope_pkg::ST_UPDATE:  cmd.upd = 1'b1;
      clope_pkg::ST_TXN:     cmd.txn = 1'b1;
      clope_pkg::ST_PMUL:    cmd.pmul = 1'b1;
      clope_pkg::ST_PCLAMP:  cmd.pclamp = 1'b1;
      clope_pkg::ST_LOGINIT: begin
        cmd.loginit = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      clope_pkg::ST_LOGSQ: begin
        cmd.logsq   = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      clope_pkg::ST_EMUL: begin
        cmd.emul    = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      clope_pkg::ST_EXPSTEP: begin
        cmd.expstep = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      clope_pkg::ST_QA:      cmd.qa = 1'b1;
      clope_pkg::ST_QB:      cmd.qb = 1'b1;
      clope_pkg::ST_QC:      cmd.qc = 1'b1;
      clope_pkg::ST_SHIFT:   cmd.shift = 1'b1;
      clope_pkg::ST_FINISH:  cmd.out_load = status.out_free;
      default:               cmd = '0;
    endcase
  end

endmodule

// File: sv/clope_dp.sv
// Datapath: occurrence memory, cluster totals, log2/exp2 quality engine, result register.
module clope_dp #(
  parameter int ITEM_IDS   = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  clope_pkg::cmd_t                   cmd,
  output clope_pkg::status_t                status,
  input  logic                              req_valid,
  input  logic [clope_pkg::KIND_W-1:0]      req_kind,
  input  logic [clope_pkg::ITEM_W-1:0]      req_item,
  input  logic                              req_last,
  input  logic                              cfg_we,
  input  logic [clope_pkg::REP_W-1:0]       cfg_data,
  input  logic                              rsp_ready,
  output logic                              rsp_valid,
  output logic signed [clope_pkg::QV_W-1:0] quality_value,
  output logic                              cluster_empty,
  output logic [clope_pkg::WID_W-1:0]       cluster_width,
  output logic [clope_pkg::TXN_W-1:0]       transaction_total,
  output logic                              missing_item,
  output logic                              saturated
);

  localparam int AW = (ITEM_IDS > 1) ? $clog2(ITEM_IDS) : 1;
  localparam int CW = (AW > 4) ? AW : 4;
  localparam logic [CW-1:0] CNT_LAST = CW'(ITEM_IDS - 1);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  // Counter shared by the clear pass and the 16-step loops
  logic [CW-1:0] cnt;
  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end
  end

  logic [clope_pkg::REP_W-1:0] repulsion;
  always_ff @(posedge clk) begin
    if (rst) begin
      repulsion <= clope_pkg::REP_RESET;
    end else if (cfg_we) begin
      repulsion <= cfg_data;
    end
  end

  // Latched item
  logic [clope_pkg::KIND_W-1:0] kind_r;
  logic [clope_pkg::ITEM_W-1:0] item_r;
  logic                         last_r;
  logic                         take;
  assign take = cmd.accept_ok && req_valid && (req_kind != clope_pkg::KIND_SKIP);
  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= req_kind;
      item_r <= req_item;
      last_r <= req_last;
    end
  end

  logic [16:0]   item_ext;
  logic          in_range;
  logic [AW-1:0] item_addr;
  assign item_ext  = 17'(item_r);
  assign in_range  = item_ext < 17'(ITEM_IDS);
  assign item_addr = item_ext[AW-1:0];

  // Occurrence memory
  logic [COUNT_BITS-1:0] mem [ITEM_IDS];
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  mem_we;
  logic [AW-1:0]         wr_addr;

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = item_addr;
    wr_data = rd_data;
    if (cmd.clr_wr) begin
      mem_we  = 1'b1;
      wr_addr = cnt[AW-1:0];
      wr_data = '0;
    end else if (cmd.upd && in_range) begin
      if (kind_r == clope_pkg::KIND_ADD) begin
        mem_we  = 1'b1;
        wr_data = (rd_data < CMAX) ? rd_data + COUNT_BITS'(1) : rd_data;
      end else if (kind_r == clope_pkg::KIND_REMOVE && rd_data != '0) begin
        mem_we  = 1'b1;
        wr_data = rd_data - COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data <= mem[item_addr];
  end

  // Cluster totals
  logic [clope_pkg::WID_W-1:0]  width_count;
  logic [clope_pkg::TOT_W-1:0]  item_total;
  logic [clope_pkg::TXN_W-1:0]  txn_count;
  logic [clope_pkg::QV_W-1:0]   current_quality;
  logic [clope_pkg::PEND_W-1:0] pending_items;
  logic [clope_pkg::PEND_W-1:0] pending_new_width;
  logic                         missing_flag;

  logic [32:0] s_in;
  logic [16:0] n_in;
  logic [13:0] w_in;
  logic        zero_f;

  logic [32:0] s_sum;
  logic [31:0] s_add;
  logic [31:0] s_sub;
  logic [15:0] n_add;
  logic [15:0] n_sub;
  assign s_sum = 33'(item_total) + 33'(pending_items);
  assign s_add = s_sum[32] ? 32'hFFFF_FFFF : s_sum[31:0];
  assign s_sub = (item_total > 32'(pending_items)) ? item_total - 32'(pending_items) : 32'd0;
  assign n_add = (txn_count != 16'hFFFF) ? txn_count + 16'd1 : txn_count;
  assign n_sub = (txn_count != 16'd0) ? txn_count - 16'd1 : txn_count;

  logic [clope_pkg::QV_W-1:0] nq;
  logic                       qsat;
  logic signed [48:0]         delta;
  logic signed [clope_pkg::QV_W-1:0] dval;
  logic                       dsat;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_count       <= '0;
      item_total        <= '0;
      txn_count         <= '0;
      current_quality   <= '0;
      pending_items     <= '0;
      pending_new_width <= '0;
      missing_flag      <= 1'b0;
    end else begin
      if (cmd.upd) begin
        if (in_range) begin
          if (pending_items != clope_pkg::PEND_MAX) pending_items <= pending_items + 13'd1;
          unique case (kind_r)
            clope_pkg::KIND_QUERY: begin
              if (rd_data == '0 && pending_new_width != clope_pkg::PEND_MAX)
                pending_new_width <= pending_new_width + 13'd1;
            end
            clope_pkg::KIND_ADD: begin
              if (rd_data == '0) width_count <= width_count + 13'd1;
            end
            clope_pkg::KIND_REMOVE: begin
              if (rd_data == '0) missing_flag <= 1'b1;
              else if (rd_data == COUNT_BITS'(1) && width_count != '0)
                width_count <= width_count - 13'd1;
            end
            default: ;
          endcase
        end else if (kind_r == clope_pkg::KIND_REMOVE) begin
          missing_flag <= 1'b1;
        end
      end
      if (cmd.txn) begin
        if (kind_r == clope_pkg::KIND_ADD) begin
          item_total <= s_add;
          txn_count  <= n_add;
        end else if (kind_r == clope_pkg::KIND_REMOVE) begin
          item_total <= s_sub;
          txn_count  <= n_sub;
        end
      end
      if (cmd.out_load) begin
        if (kind_r != clope_pkg::KIND_QUERY) current_quality <= nq;
        pending_items     <= '0;
        pending_new_width <= '0;
        missing_flag      <= 1'b0;
      end
    end
  end

  // Quality engine
  logic [49:0] prod;
  logic [47:0] p;
  logic        psat;
  logic [3:0]  lk;
  logic [15:0] frac;
  logic [31:0] x;
  logic [23:0] e;
  logic [32:0] m;
  logic [63:0] pa;
  logic [63:0] pb;
  logic [47:0] q;
  logic [47:0] shift_val;
  logic        shift_sat;

  logic [3:0]  k_c;
  logic [61:0] sq;
  logic [31:0] xs;
  logic [35:0] emul_p;
  logic [3:0]  jdx;
  logic        ebit;
  logic [31:0] tk;
  logic [63:0] mt;
  logic [64:0] qsum;

  always_comb begin
    k_c = 4'd0;
    for (int i = 1; i < 14; i++) begin
      if (w_in[i]) k_c = 4'(i);
    end
  end

  assign sq     = 62'(x[30:0]) * 62'(x[30:0]);
  assign xs     = sq[61:30];
  assign emul_p = 36'(repulsion) * 36'({lk, frac});
  assign jdx    = cnt[3:0];
  assign ebit   = e[4'd15 - jdx];
  assign tk     = clope_pkg::TK[jdx];
  assign mt     = 64'(m[31:0]) * 64'(tk);
  assign qsum   = 65'(pa) + 65'(pb[63:16]);

  always_ff @(posedge clk) begin
    if (cmd.txn) begin
      unique case (kind_r)
        clope_pkg::KIND_ADD: begin
          s_in <= 33'(s_add);
          n_in <= 17'(n_add);
          w_in <= 14'(width_count);
        end
        clope_pkg::KIND_REMOVE: begin
          s_in <= 33'(s_sub);
          n_in <= 17'(n_sub);
          w_in <= 14'(width_count);
        end
        default: begin
          s_in <= s_sum;
          n_in <= 17'(txn_count) + 17'd1;
          w_in <= 14'(width_count) + 14'(pending_new_width);
        end
      endcase
    end
    if (cmd.pmul) begin
      prod   <= 50'(s_in) * 50'(n_in);
      zero_f <= (n_in == '0) || (w_in == '0);
    end
    if (cmd.pclamp) begin
      psat <= prod > 50'(clope_pkg::Q48_MAX);
      p    <= (prod > 50'(clope_pkg::Q48_MAX)) ? clope_pkg::Q48_MAX : prod[47:0];
    end
    if (cmd.loginit) begin
      lk   <= k_c;
      x    <= 32'(w_in) << (5'd30 - 5'(k_c));
      frac <= '0;
    end
    if (cmd.logsq) begin
      frac <= {frac[14:0], xs[31]};
      x    <= xs[31] ? (xs >> 1) : xs;
    end
    if (cmd.emul) begin
      e <= emul_p[35:12];
      m <= 33'd1 << 32;
    end
    if (cmd.expstep && ebit) begin
      m <= m[32] ? 33'(tk) : 33'(mt[63:32]);
    end
    if (cmd.qa) pa <= 64'(p) * 64'(m[31:16]);
    if (cmd.qb) pb <= 64'(p) * 64'(m[15:0]);
    if (cmd.qc) q <= m[32] ? p : qsum[63:16];
    if (cmd.shift) begin
      nq   <= shift_val;
      qsat <= shift_sat;
    end
  end

  // Final scale by 2^(16-Ei)
  logic [7:0]  ei;
  logic [4:0]  sh;
  logic [7:0]  dr;
  assign ei = e[23:16];
  always_comb begin
    sh        = 5'(8'd16 - ei);
    dr        = ei - 8'd16;
    shift_sat = 1'b0;
    if (zero_f) begin
      shift_val = '0;
    end else if (ei <= 8'd16) begin
      if (q > (clope_pkg::Q48_MAX >> sh)) begin
        shift_val = clope_pkg::Q48_MAX;
        shift_sat = 1'b1;
      end else begin
        shift_val = q << sh;
      end
      shift_sat = shift_sat | psat;
    end else begin
      shift_val = (dr >= 8'd48) ? 48'd0 : (q >> dr[5:0]);
      shift_sat = psat;
    end
  end

  // Query delta, clamped to signed 48 bits
  assign delta = signed'({1'b0, nq}) - signed'({1'b0, current_quality});
  always_comb begin
    dsat = 1'b0;
    dval = delta[47:0];
    if (delta > 49'sh0_7FFF_FFFF_FFFF) begin
      dval = 48'sh7FFF_FFFF_FFFF;
      dsat = 1'b1;
    end else if (delta < -49'sh0_8000_0000_0000) begin
      dval = 48'sh8000_0000_0000;
      dsat = 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      quality_value     <= (kind_r == clope_pkg::KIND_QUERY) ? dval : signed'(nq);
      saturated         <= qsat | ((kind_r == clope_pkg::KIND_QUERY) & dsat);
      cluster_empty     <= txn_count == '0;
      cluster_width     <= width_count;
      transaction_total <= txn_count;
      missing_item      <= (kind_r == clope_pkg::KIND_REMOVE) & missing_flag;
    end
  end

  assign status.clr_done  = cnt == CNT_LAST;
  assign status.iter_done = cnt[3:0] == 4'hF;
  assign status.req_skip  = req_kind == clope_pkg::KIND_SKIP;
  assign status.item_last = last_r;
  assign status.out_free  = !rsp_valid || rsp_ready;

endmodule

// File: sv/clope_cluster_profit_update_top.sv
// Top level: one CLOPE cluster with fixed-point quality S*N/W^r.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+----------------------------------------------
//  req     | in  | valid/ready  | kind, item, last
//  rsp     | out | valid/ready  | quality_value, cluster_empty, cluster_width,
//          |     |              | transaction_total, missing_item, saturated
//  cfg     | in  | valid/ready  | data (repulsion, Q4.12)
//
// Each item passes through accept, memory read and read-modify-write of its
// counter. A last item then computes the quality: one multiply S*N, 16
// squaring steps for log2(W), 16 table multiplies for 2^-frac on the shared
// counter, then scaling. Kind 3 items are taken in idle and dropped.
// After reset, a clearing pass zeroes the counter table, with req.ready low;
// cfg writes are taken at any time. A stalled result holds in the output
// register; the next item is taken meanwhile and only its result waits.
module clope_cluster_profit_update_top #(
  parameter int ITEM_IDS   = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  clope_req_if.sink   req,
  clope_rsp_if.source rsp,
  clope_cfg_if.sink   cfg
);

  clope_pkg::cmd_t    cmd;
  clope_pkg::status_t status;

  // Accept items only when the controller waits for one; kind 3 drops in idle
  assign req.ready = cmd.accept_ok;
  // Register writes land at once
  assign cfg.ready = 1'b1;

  clope_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .status    (status),
    .cmd       (cmd)
  );

  clope_dp #(
    .ITEM_IDS   (ITEM_IDS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .req_valid         (req.valid),
    .req_kind          (req.kind),
    .req_item          (req.item),
    .req_last          (req.last),
    .cfg_we            (cfg.valid),
    .cfg_data          (cfg.data),
    .rsp_ready         (rsp.ready),
    .rsp_valid         (rsp.valid),
    .quality_value     (rsp.quality_value),
    .cluster_empty     (rsp.cluster_empty),
    .cluster_width     (rsp.cluster_width),
    .transaction_total (rsp.transaction_total),
    .missing_item      (rsp.missing_item),
    .saturated         (rsp.saturated)
  );

endmodule

// File: sv/clope_checker.sv
// Checker: port-level assertions on the cluster block, bound to the top level.
module clope_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [clope_pkg::QV_W-1:0] quality_value,
  input logic                              cluster_empty,
  input logic [clope_pkg::TXN_W-1:0]       transaction_total
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(quality_value))
    else $error("result payload changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (cluster_empty == (transaction_total == '0)))
    else $error("empty flag disagrees with transaction total");

  // Clearing pass blocks items right after reset
  a_clear: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("item accepted during clearing pass");

endmodule

bind clope_cluster_profit_update_top clope_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .quality_value     (rsp.quality_value),
  .cluster_empty     (rsp.cluster_empty),
  .transaction_total (rsp.transaction_total)
);

// File: bench/clope_cluster_profit_update_top_test.sv
// Testbench for one CLOPE cluster: directed table, then random transactions checked against a predictor.
`timescale 1ns / 100ps

module clope_cluster_profit_update_top_test;

  localparam int CYCLE_LIMIT = 20000;
  localparam int NUM_IDS = 4096;
  localparam logic [63:0] SAT48 = (64'd1 << 48) - 64'd1;

  typedef struct packed {
    logic [clope_pkg::KIND_W-1:0] kind;
    logic [clope_pkg::ITEM_W-1:0] item;
    logic                         last;
  } cluster_item_t;

  typedef struct packed {
    logic [clope_pkg::QV_W-1:0]  quality_value;
    logic                        cluster_empty;
    logic [clope_pkg::WID_W-1:0] cluster_width;
    logic [clope_pkg::TXN_W-1:0] transaction_total;
    logic                        missing_item;
    logic                        saturated;
  } profit_result_t;

  // Directed row: one item, plus an optional typed-in expectation.
  typedef struct packed {
    cluster_item_t  stim;
    logic           fixed;
    profit_result_t want;
  } directed_row_t;

  logic clk;
  logic rst;

  clope_req_if req ();
  clope_rsp_if rsp ();
  clope_cfg_if cfg ();

  clope_cluster_profit_update_top u_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source),
    .cfg(cfg.sink)
  );

  // Predictor state of the cluster.
  logic [15:0] occ_count [NUM_IDS];
  logic [12:0] cl_width;
  logic [31:0] cl_items;
  logic [15:0] cl_txns;
  logic [47:0] cl_quality;
  logic [12:0] pend_items;
  logic [12:0] pend_width;
  logic        pend_missing;
  logic [15:0] rep_exp;

  profit_result_t expected_profits[$];
  profit_result_t typed_want;
  bit typed_armed = 0;
  int errors = 0;
  int idle_cycles = 0;
  bit hold_kick = 0;
  int hold_left = 0;
  int rsp_stall_pct = 20;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] root64(input logic [63:0] n_in);
    logic [63:0] n, res, b;
    n = n_in;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] log2_fix(input logic [63:0] w);
    logic [63:0] x, frac;
    int k;
    k = 0;
    frac = 0;
    while (k < 40 && (w >> (k + 1)) != 0) k++;
    x = (k <= 30) ? (w << (30 - k)) : (w >> (k - 30));
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd2 << 30)) begin
        frac = frac | 1;
        x = x >> 1;
      end
    end
    return (64'(k) << 16) | frac;
  endfunction

  // Quality S*N/W^r in Q32.16, with the saturation flag.
  function automatic logic [63:0] profit_of(input logic [63:0] s, input logic [63:0] n,
                                            input logic [63:0] w, inout bit sat);
    logic [63:0] p, e, ei, ef, m, t, q;
    if (n == 0 || w == 0) return 0;
    p = s * n;
    if (p > SAT48) begin
      p = SAT48;
      sat = 1;
    end
    e = (64'(rep_exp) * log2_fix(w)) >> 12;
    ei = e >> 16;
    ef = e & 64'hFFFF;
    m = 64'd1 << 32;
    t = root64(64'd1 << 63);
    for (int k = 15; k >= 0; k--) begin
      if (ef[k]) m = (m * t) >> 32;
      t = root64(t << 32);
    end
    if (m == (64'd1 << 32)) q = p;
    else q = (p * (m >> 16) + ((p * (m & 64'hFFFF)) >> 16)) >> 16;
    if (ei <= 16) begin
      if (q > (SAT48 >> (16 - ei))) begin
        sat = 1;
        return SAT48;
      end
      return q << (16 - ei);
    end
    if (ei - 16 >= 64) return 0;
    return q >> (ei - 16);
  endfunction

  task automatic reset_cluster();
    for (int i = 0; i < NUM_IDS; i++) occ_count[i] = 0;
    cl_width = 0;
    cl_items = 0;
    cl_txns = 0;
    cl_quality = 0;
    pend_items = 0;
    pend_width = 0;
    pend_missing = 0;
    rep_exp = clope_pkg::REP_RESET;
  endtask

  // Advance the cluster by one accepted item; return a result on a last item other than kind 3.
  task automatic advance_cluster(input cluster_item_t it, output bit made,
                                 output profit_result_t r);
    bit sat;
    logic [63:0] nq, sum;
    longint d;
    sat = 0;
    made = 0;
    r = '0;
    if (it.kind == clope_pkg::KIND_SKIP) return;
    if (pend_items < clope_pkg::PEND_MAX) pend_items++;
    if (it.kind == clope_pkg::KIND_QUERY) begin
      if (occ_count[it.item] == 0 && pend_width < clope_pkg::PEND_MAX) pend_width++;
    end else if (it.kind == clope_pkg::KIND_ADD) begin
      if (occ_count[it.item] == 0) cl_width++;
      if (occ_count[it.item] != 16'hFFFF) occ_count[it.item]++;
    end else begin
      if (occ_count[it.item] == 0) pend_missing = 1;
      else begin
        occ_count[it.item]--;
        if (occ_count[it.item] == 0 && cl_width > 0) cl_width--;
      end
    end
    if (!it.last) return;
    if (it.kind == clope_pkg::KIND_QUERY) begin
      nq = profit_of(64'(cl_items) + pend_items, 64'(cl_txns) + 1,
                     64'(cl_width) + pend_width, sat);
      d = longint'(nq) - longint'({16'd0, cl_quality});
      if (d > (longint'(1) <<< 47) - 1) begin
        d = (longint'(1) <<< 47) - 1;
        sat = 1;
      end
      if (d < -(longint'(1) <<< 47)) begin
        d = -(longint'(1) <<< 47);
        sat = 1;
      end
      r.quality_value = d[47:0];
    end else begin
      if (it.kind == clope_pkg::KIND_ADD) begin
        sum = 64'(cl_items) + pend_items;
        cl_items = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        if (cl_txns != 16'hFFFF) cl_txns++;
      end else begin
        cl_items = (cl_items > pend_items) ? cl_items - pend_items : 0;
        if (cl_txns > 0) cl_txns--;
      end
      cl_quality = profit_of(cl_items, cl_txns, cl_width, sat);
      r.quality_value = cl_quality;
    end
    r.cluster_empty = (cl_txns == 0);
    r.cluster_width = cl_width;
    r.transaction_total = cl_txns;
    r.missing_item = (it.kind == clope_pkg::KIND_REMOVE) ? pend_missing : 1'b0;
    r.saturated = sat;
    made = 1;
    pend_items = 0;
    pend_width = 0;
    pend_missing = 0;
  endtask

  // Predict on every accepted transaction at the edge itself.
  always @(posedge clk) begin
    bit made;
    profit_result_t r;
    if (!rst && req.valid && req.ready) begin
      advance_cluster('{req.kind, req.item, req.last}, made, r);
      if (made) expected_profits.push_back(r);
    end
  end

  // Check each accepted result against the oldest expectation, and a typed-in one.
  always @(posedge clk) begin
    profit_result_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.quality_value, rsp.cluster_empty, rsp.cluster_width,
              rsp.transaction_total, rsp.missing_item, rsp.saturated};
      if (typed_armed) begin
        typed_armed = 0;
        if (got !== typed_want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h actual %h", typed_want, got);
        end
      end
      if (expected_profits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_profits.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // Receiver: random stall pattern, or a long hold-off counted here when kicked.
  always @(posedge clk) begin
    if (hold_kick) begin
      hold_kick = 0;
      hold_left = 400;
    end
    if (rst) rsp.ready <= 1'b0;
    else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left--;
    end else rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // Watchdog: count cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= CYCLE_LIMIT) begin
      $display("clope_cluster_profit_update_top_test failed");
      $finish;
    end
  end

  task automatic send_item(input cluster_item_t it);
    req.valid <= 1'b1;
    req.kind <= it.kind;
    req.item <= it.item;
    req.last <= it.last;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drop_valid();
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every result, then let a full quality pass drain.
  task automatic drain();
    drop_valid();
    while (expected_profits.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_repulsion(input logic [15:0] v);
    drain();
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    rep_exp = v;
    @(posedge clk);
  endtask

  int burst_left = 0;
  // Sender pacing: bursts of random length, then random gaps.
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(3) == 0) begin
        drop_valid();
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Random transaction; mostly well-formed, some noise.
  task automatic send_random_txn(input int max_len, input int id_span);
    int len;
    logic [clope_pkg::KIND_W-1:0] k;
    cluster_item_t it;
    len = $urandom_range(1, max_len);
    k = clope_pkg::KIND_W'($urandom_range(2));
    for (int i = 0; i < len; i++) begin
      pace();
      it.kind = k;
      if ($urandom_range(15) == 0) it.kind = clope_pkg::KIND_W'($urandom_range(3));
      it.item = ($urandom_range(7) == 0) ? clope_pkg::ITEM_W'($urandom) :
                clope_pkg::ITEM_W'($urandom_range(id_span));
      it.last = (i == len - 1);
      send_item(it);
    end
  endtask

  directed_row_t directed[] = '{
    // after reset: query on empty cluster, one item; S=1 N=1 W=1 -> 1.0
    '{'{clope_pkg::KIND_QUERY, 12'd0, 1'b1}, 1'b1,
      '{48'h10000, 1'b1, 13'd0, 16'd0, 1'b0, 1'b0}},
    // remove on empty cluster: missing, stays empty
    '{'{clope_pkg::KIND_REMOVE, 12'd5, 1'b1}, 1'b1,
      '{48'h0, 1'b1, 13'd0, 16'd0, 1'b1, 1'b0}},
    '{'{clope_pkg::KIND_SKIP, 12'hFFF, 1'b1}, 1'b0, '0},
    // add {0}: S=1 N=1 W=1
    '{'{clope_pkg::KIND_ADD, 12'd0, 1'b1}, 1'b1,
      '{48'h10000, 1'b0, 13'd1, 16'd1, 1'b0, 1'b0}},
    '{'{clope_pkg::KIND_ADD, 12'hFFF, 1'b0}, 1'b0, '0},
    '{'{clope_pkg::KIND_ADD, 12'd1, 1'b1}, 1'b0, '0},
    '{'{clope_pkg::KIND_QUERY, 12'hFFF, 1'b0}, 1'b0, '0},
    '{'{clope_pkg::KIND_QUERY, 12'd77, 1'b0}, 1'b0, '0},
    '{'{clope_pkg::KIND_QUERY, 12'd77, 1'b1}, 1'b0, '0},
    // mixed kinds, last decides
    '{'{clope_pkg::KIND_ADD, 12'd9, 1'b0}, 1'b0, '0},
    '{'{clope_pkg::KIND_QUERY, 12'd10, 1'b1}, 1'b0, '0},
    '{'{clope_pkg::KIND_REMOVE, 12'hFFF, 1'b0}, 1'b0, '0},
    '{'{clope_pkg::KIND_REMOVE, 12'd300, 1'b1}, 1'b0, '0},
    '{'{clope_pkg::KIND_REMOVE, 12'd0, 1'b1}, 1'b0, '0},
    '{'{clope_pkg::KIND_REMOVE, 12'd1, 1'b1}, 1'b0, '0},
    '{'{clope_pkg::KIND_REMOVE, 12'd9, 1'b1}, 1'b0, '0},
    // remove below zero: N floors at 0
    '{'{clope_pkg::KIND_REMOVE, 12'd2, 1'b1}, 1'b0, '0},
    '{'{clope_pkg::KIND_SKIP, 12'd0, 1'b0}, 1'b0, '0}
  };

  initial begin
    int half;
    rst = 1'b1;
    req.valid = 1'b0;
    req.kind = '0;
    req.item = '0;
    req.last = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    reset_cluster();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; rows with a typed-in result are checked against it as well.
    foreach (directed[i]) begin
      if (directed[i].fixed) begin
        drain();
        typed_want = directed[i].want;
        typed_armed = 1;
      end
      send_item(directed[i].stim);
      if (directed[i].fixed) drain();
    end
    drain();

    // Random phases across repulsion settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      logic [15:0] rv;
      case (ph)
        0: rv = 16'd0;
        1: rv = 16'hFFFF;
        2: rv = 16'd4096;
        default: rv = 16'($urandom);
      endcase
      write_repulsion(rv);
      half = 0;
      while (half < 230) begin
        send_random_txn(8, (ph == 3) ? 4095 : 63);
        half += 4;
        // Long receiver hold-off while the sender keeps offering items.
        if (ph == 2 && half == 100) hold_kick = 1;
        // Sender pause until every result has come.
        if (ph == 4 && half == 100) drain();
      end
    end
    // Wide transactions on a big span to touch high widths.
    write_repulsion(16'd8192);
    for (int i = 0; i < 3; i++) send_random_txn(60, 4095);

    drain();
    if (errors == 0 && expected_profits.size() == 0) begin
      $display("clope_cluster_profit_update_top_test passed");
    end else begin
      $display("clope_cluster_profit_update_top_test failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/clope_pkg.sv
sv/clope_if.sv
sv/clope_ctrl.sv
sv/clope_dp.sv
sv/clope_cluster_profit_update_top.sv
sv/clope_checker.sv
bench/clope_cluster_profit_update_top_test.sv
